### rtl/fault_retry_lockout_supervisor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fault retry / lockout supervisor
// Every macro expects clk and rst_n in scope and is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FAULT_RETRY_LOCKOUT_SUPERVISOR_ASSERT_SVH
`define FAULT_RETRY_LOCKOUT_SUPERVISOR_ASSERT_SVH

// Condition holds at every edge
`define FRLS_CHECK(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("frls: invariant violated");

// Antecedent implies consequent in the same cycle
`define FRLS_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frls: implication violated");

// Antecedent implies consequent in the next cycle
`define FRLS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frls: sequence violated");

`endif

### rtl/frls_pkg.sv
// ----------------------------------------------------------------------------
// frls_pkg
// Shared widths, reset values, register indexes and types of the supervisor.
// ----------------------------------------------------------------------------
package frls_pkg;

  localparam int unsigned ID_W        = 4;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned TMR_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [CNT_W-1:0] RST_LOCKOUT = CNT_W'(10);
  localparam logic [CNT_W-1:0] RST_SILENT  = CNT_W'(10);
  localparam logic [TMR_W-1:0] RST_RELEASE = TMR_W'(10 * 60 * 10);

  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENT_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS = 2'd2;

  // One store entry per fault id
  typedef struct packed {
    logic [TMR_W-1:0] rel;
    logic [CNT_W-1:0] sil;
    logic [CNT_W-1:0] lock;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic rd_op;
    logic exec;
    logic rd_out;
    logic load_out;
  } cmd_t;

endpackage

### rtl/frls_ctrl.sv
// ----------------------------------------------------------------------------
// frls_ctrl
// Sequencer: capture, operand read, execute, result read, output load.
// ----------------------------------------------------------------------------
`include "fault_retry_lockout_supervisor_assert.svh"

module frls_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output frls_pkg::cmd_t cmd
);
  import frls_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDOP,
    S_EXEC,
    S_RDOUT,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_RDOP;
        end
      end
      S_RDOP: begin
        cmd.rd_op = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RDOUT;
      end
      S_RDOUT: begin
        cmd.rd_out = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `FRLS_NEXT(a_accept_reads, in_tvalid && in_tready, state_r == S_RDOP)
  `FRLS_NEXT(a_load_sets_valid, cmd.load_out, out_valid_r)
  `FRLS_CHECK(a_one_cmd, $onehot0({cmd.capture, cmd.rd_op, cmd.exec, cmd.rd_out, cmd.load_out}))

endmodule

### rtl/frls_dpath.sv
// ----------------------------------------------------------------------------
// frls_dpath
// Per-id store memory, configuration registers, update logic, result register.
// ----------------------------------------------------------------------------
`include "fault_retry_lockout_supervisor_assert.svh"

module frls_dpath #(
  parameter int unsigned NUM_IDS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  frls_pkg::cmd_t                  cmd,
  input  logic                            item_req,
  input  logic [frls_pkg::ID_W-1:0]       item_cid,
  input  logic [frls_pkg::ID_W-1:0]       item_rep,
  input  logic                            item_comp,
  input  logic                            cfg_we,
  input  logic [frls_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [frls_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                            res_fault,
  output logic                            res_clear,
  output logic                            res_protect,
  output logic [frls_pkg::ID_W-1:0]       res_latched,
  output logic [frls_pkg::CNT_W-1:0]      res_lockout,
  output logic [frls_pkg::CNT_W-1:0]      res_silent
);
  import frls_pkg::*;

  localparam int unsigned AW = $clog2(NUM_IDS);

  logic             req_r, comp_r;
  logic [ID_W-1:0]  cid_r, rep_r;
  logic [CNT_W-1:0] lock_lim_r, sil_lim_r, snap_lock_r, snap_sil_r;
  logic [TMR_W-1:0] rel_ticks_r, snap_rel_r;
  logic [ID_W-1:0]  latched_r, latched_nxt;
  logic             flt_r, clr_r, prot_r;
  logic             flt_nxt, clr_nxt, prot_nxt;

  entry_t           mem_r [NUM_IDS];
  logic [NUM_IDS-1:0] vld_r;
  entry_t           rd_word_r;
  logic             rd_vld_r;

  logic             cid_ok, rep_ok;
  logic [AW-1:0]    op_addr, rd_addr;
  entry_t           eff, new_entry;
  logic             wr_en, reload;

  assign cid_ok  = (cid_r != '0) && (32'(cid_r) < NUM_IDS);
  assign rep_ok  = (rep_r != '0) && (32'(rep_r) < NUM_IDS);
  assign op_addr = req_r ? cid_r[AW-1:0] : rep_r[AW-1:0];
  assign rd_addr = cmd.rd_out ? cid_r[AW-1:0] : op_addr;

  // an entry not written since the last restore reads the restore snapshot
  always_comb begin
    if (rd_vld_r) begin
      eff = rd_word_r;
    end else begin
      eff.rel  = snap_rel_r;
      eff.sil  = snap_sil_r;
      eff.lock = snap_lock_r;
    end
  end

  always_comb begin
    wr_en       = 1'b0;
    reload      = 1'b0;
    new_entry   = eff;
    latched_nxt = latched_r;
    flt_nxt     = 1'b0;
    clr_nxt     = 1'b0;
    prot_nxt    = 1'b0;
    if (!req_r) begin
      if (rep_ok) begin
        latched_nxt = rep_r;
        wr_en       = 1'b1;
        if (eff.sil != '0) begin
          new_entry.sil = eff.sil - 8'd1;
          clr_nxt       = 1'b1;
        end else begin
          new_entry.sil = sil_lim_r;
          if (eff.lock != '0) begin
            new_entry.lock = eff.lock - 8'd1;
          end
          prot_nxt = 1'b1;
          flt_nxt  = 1'b1;
        end
      end
    end else if (cid_ok) begin
      if (latched_r != '0) begin
        if (eff.lock == '0) begin
          flt_nxt = 1'b1;
        end else if (latched_r == cid_r) begin
          latched_nxt = '0;
        end
      end else begin
        wr_en = 1'b1;
        if (eff.rel != '0) begin
          new_entry.rel = eff.rel - 16'd1;
        end else begin
          reload         = 1'b1;
          new_entry.lock = lock_lim_r;
          new_entry.sil  = sil_lim_r;
          new_entry.rel  = rel_ticks_r;
        end
        if (!comp_r || (new_entry.lock >= lock_lim_r && new_entry.sil >= sil_lim_r)) begin
          new_entry.rel = rel_ticks_r;
        end
      end
    end
  end

  // store memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem_r[op_addr] <= new_entry;
    end
    if (cmd.rd_op || cmd.rd_out) begin
      rd_word_r <= mem_r[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  // item capture, flags and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= item_req;
      cid_r  <= item_cid;
      rep_r  <= item_rep;
      comp_r <= item_comp;
    end
    if (cmd.exec) begin
      flt_r  <= flt_nxt;
      clr_r  <= clr_nxt;
      prot_r <= prot_nxt;
    end
    if (cmd.load_out) begin
      res_fault   <= flt_r;
      res_clear   <= clr_r;
      res_protect <= prot_r;
      res_latched <= latched_r;
      res_lockout <= cid_ok ? eff.lock : '0;
      res_silent  <= cid_ok ? eff.sil : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_lim_r  <= RST_LOCKOUT;
      sil_lim_r   <= RST_SILENT;
      rel_ticks_r <= RST_RELEASE;
      snap_lock_r <= RST_LOCKOUT;
      snap_sil_r  <= RST_SILENT;
      snap_rel_r  <= RST_RELEASE;
      latched_r   <= '0;
      vld_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_LOCKOUT_LIMIT: lock_lim_r  <= cfg_wdata[CNT_W-1:0];
          CFG_SILENT_LIMIT:  sil_lim_r   <= cfg_wdata[CNT_W-1:0];
          CFG_RELEASE_TICKS: rel_ticks_r <= cfg_wdata[TMR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        latched_r <= latched_nxt;
        if (reload) begin
          // a restore leaves only the entry written now as current
          snap_lock_r <= lock_lim_r;
          snap_sil_r  <= sil_lim_r;
          snap_rel_r  <= rel_ticks_r;
          vld_r       <= NUM_IDS'(1) << op_addr;
        end else if (wr_en) begin
          vld_r[op_addr] <= 1'b1;
        end
      end
    end
  end

  `FRLS_CHECK(a_latched_range, 32'(latched_r) < NUM_IDS)
  `FRLS_IMPLY(a_no_entry0_write, cmd.exec && wr_en, op_addr != '0)
  `FRLS_CHECK(a_entry0_invalid, !vld_r[0])

endmodule

### rtl/fault_retry_lockout_supervisor.sv
// ----------------------------------------------------------------------------
// fault_retry_lockout_supervisor
// Motor-drive fault supervisor with silent retries, lockout retries and a
// fault-free release timer per fault id.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one transfer per supervisor request. in_tuser is the request
//   kind (0 protect check of the reported fault, 1 error check of check_id).
//   Output stream: one transfer per request with the flags, the latched id and
//   the remaining retry counts of check_id.
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 lockout
//   limit, 1 silent retry limit, 2 release ticks); other indexes are ignored.
//   Write it only while no request is in flight.
// Timing:
//   A request passes through capture, store read, update/write, store read of
//   check_id and output load; a new request is taken only once it is done. The
//   result becomes valid and in_tready rises again in the same cycle. The single-port
//   store memory (one access per cycle) is why these steps run one after another.
// Reset and stall:
//   rst_n (synchronous, low) restores the registers, clears the latch and marks
//   every store entry as holding its restore value, with no clearing pass.
//   A stalled receiver holds the result in the output register; the block
//   finishes the next request and waits in its output step until it drains.
// ----------------------------------------------------------------------------
module fault_retry_lockout_supervisor #(
  parameter int unsigned NUM_IDS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [3:0] check_id, [7:4] reported_fault, [8] compressor_on, [15:9] zero
  input  logic [frls_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] req_type
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] fault, [1] clear_drive_fault, [2] assert_protect, [6:3] latched_fault,
  // [14:7] lockout_left, [22:15] silent_left, [23] zero
  output logic [frls_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [frls_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [frls_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import frls_pkg::*;

  cmd_t             cmd;
  logic             res_fault, res_clear, res_protect;
  logic [ID_W-1:0]  res_latched;
  logic [CNT_W-1:0] res_lockout, res_silent;

  // sequencing and handshake
  frls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd)
  );

  // stores, update rules and result register
  frls_dpath #(
    .NUM_IDS(NUM_IDS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .item_req   (in_tuser),
    .item_cid   (in_tdata[3:0]),
    .item_rep   (in_tdata[7:4]),
    .item_comp  (in_tdata[8]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .res_fault  (res_fault),
    .res_clear  (res_clear),
    .res_protect(res_protect),
    .res_latched(res_latched),
    .res_lockout(res_lockout),
    .res_silent (res_silent)
  );

  // pack the result, pad to whole bytes
  assign out_tdata = {1'b0, res_silent, res_lockout, res_latched,
                      res_protect, res_clear, res_fault};

endmodule
